FILE: hw/rtl/b64d_pkg.sv
// b64d_pkg: shared types, constants and the character lookup for the base64 stream decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package b64d_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] MAX_OUTPUT_RESET = 16'hFFFF;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef enum logic [1:0] {
    CLS_BLANK,
    CLS_CODE,
    CLS_STOP
  } char_class_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       final_char;
  } dec_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
    logic        status;
    logic        last;
  } dec_out_t;

  // work handed from the front to the back: an optional byte and an optional summary
  typedef struct packed {
    logic        has_byte;
    logic        has_sum;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
    logic        status;
  } b64d_job_t;

  typedef struct packed {
    char_class_t cls;
    logic [5:0]  sextet;
  } char_info_t;

  function automatic char_info_t classify(input logic [7:0] c);
    char_info_t info;
    info.cls    = CLS_STOP;
    info.sextet = 6'd0;
    if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
      info.cls = CLS_BLANK;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      info.cls    = CLS_CODE;
      info.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      info.cls    = CLS_CODE;
      info.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      info.cls    = CLS_CODE;
      info.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      info.cls    = CLS_CODE;
      info.sextet = 6'd62;
    end else if (c == 8'h2F) begin
      info.cls    = CLS_CODE;
      info.sextet = 6'd63;
    end
    return info;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/b64d_front.sv
// b64d_front: accepts characters, classifies them and updates the bit buffer and counters
// uses b64d_pkg; pushes one job per character that yields a result into b64d_queue
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dec_in_t   in_data,
  input  wire logic      full,
  output logic           push,
  output b64d_job_t      job
);

  logic [15:0] max_output;
  logic [11:0] bit_buffer;
  logic [2:0]  bits_held;
  logic [15:0] out_count;
  logic        halted;
  logic        overflowed;

  logic [11:0] bit_buffer_next;
  logic [2:0]  bits_held_next;
  logic [15:0] out_count_next;
  logic        halted_next;
  logic        overflowed_next;

  char_info_t  info;
  logic        accept;
  logic [3:0]  held;
  logic [3:0]  held_sub;
  logic [11:0] shifted;
  logic        emit;
  logic [7:0]  byte_val;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign info     = classify(in_data.char_in);
  assign held     = {1'b0, bits_held} + 4'd6;
  assign held_sub = held - 4'd8;
  assign shifted  = {bit_buffer[5:0], info.sextet};

  always_comb begin
    unique case (held_sub[2:0])
      3'd2:    byte_val = shifted[9:2];
      3'd4:    byte_val = shifted[11:4];
      default: byte_val = shifted[7:0];
    endcase
  end

  always_comb begin
    bit_buffer_next = bit_buffer;
    bits_held_next  = bits_held;
    out_count_next  = out_count;
    halted_next     = halted;
    overflowed_next = overflowed;
    emit            = 1'b0;
    if (!halted && !overflowed && info.cls != CLS_BLANK) begin
      if (info.cls == CLS_STOP) begin
        halted_next = 1'b1;
      end else begin
        bit_buffer_next = shifted;
        bits_held_next  = held[2:0];
        if (held >= 4'd8) begin
          bits_held_next = held_sub[2:0];
          if (out_count >= max_output) begin
            overflowed_next = 1'b1;
          end else begin
            emit           = 1'b1;
            out_count_next = out_count + 16'd1;
          end
        end
      end
    end
  end

  always_comb begin
    job.has_byte   = emit;
    job.has_sum    = in_data.final_char;
    job.data_byte  = byte_val;
    job.byte_count = out_count_next;
    job.status     = overflowed_next ? STATUS_OVERFLOW : STATUS_OK;
    push           = accept && (emit || in_data.final_char);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output <= MAX_OUTPUT_RESET;
    end else if (cfg_we) begin
      max_output <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer <= '0;
      bits_held  <= '0;
      out_count  <= '0;
      halted     <= 1'b0;
      overflowed <= 1'b0;
    end else if (accept) begin
      if (in_data.final_char) begin
        // message done, start the next one clean
        bit_buffer <= '0;
        bits_held  <= '0;
        out_count  <= '0;
        halted     <= 1'b0;
        overflowed <= 1'b0;
      end else begin
        bit_buffer <= bit_buffer_next;
        bits_held  <= bits_held_next;
        out_count  <= out_count_next;
        halted     <= halted_next;
        overflowed <= overflowed_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/b64d_queue.sv
// b64d_queue: short job fifo between the decoder front and the result back end
// uses b64d_pkg for the job type and depth
`default_nettype none

module b64d_queue
  import b64d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire b64d_job_t push_job,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output b64d_job_t      head
);

  b64d_job_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("job popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/b64d_back.sv
// b64d_back: expands queued jobs into data and summary results behind an output register
// uses b64d_pkg; reads the head of b64d_queue
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      head_valid,
  input  wire b64d_job_t head,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output dec_out_t       out_data
);

  logic     load;
  logic     byte_done;
  logic     send_byte;
  dec_out_t result;

  assign load      = !out_valid || out_ready;
  assign send_byte = head.has_byte && !byte_done;
  // a job with both a byte and a summary stays at the head until its summary is loaded
  assign pop       = load && head_valid && !(send_byte && head.has_sum);

  always_comb begin
    if (send_byte) begin
      result.kind       = KIND_DATA;
      result.data_byte  = head.data_byte;
      result.byte_count = head.byte_count;
      result.status     = STATUS_OK;
      result.last       = !head.has_sum;
    end else begin
      result.kind       = KIND_SUMMARY;
      result.data_byte  = 8'd0;
      result.byte_count = head.byte_count;
      result.status     = head.status;
      result.last       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_done <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        byte_done <= send_byte && head.has_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_data <= result;
    end
  end

  a_byte_done_head: assert property (@(posedge clk) disable iff (rst)
    byte_done |-> (head_valid && head.has_byte && head.has_sum))
    else $error("byte marked sent without a pending byte and summary job");

endmodule

`default_nettype wire

FILE: hw/rtl/base64_stream_decoder_top.sv
// base64_stream_decoder_top: streaming base64 decoder, one character per transaction
// uses b64d_pkg, b64d_front, b64d_queue and b64d_back
//
// input channel (in_valid/in_ready/in_data): one character code and a final mark.
// whitespace is skipped, '=' or a non-alphabet character stops decoding until the
// final character. output channel (out_valid/out_ready/out_data): decoded bytes
// (kind 0) and one summary (kind 1) per message with byte count and status.
// cfg_we/cfg_data write max_output, the byte capacity; write only while idle.
// throughput: one character per cycle while the job queue is not full; a character that
// completes a byte and ends the message gives two results, sent one after the other.
// a taken character's job is written into the job queue at the accepting edge, and its
// result is loaded from the queue head into the output register that drives out_valid.
// a stalled receiver fills the output register and then the two-entry job queue,
// after which in_ready drops. reset clears all message state, empties the queue and
// sets max_output to 65535.
`default_nettype none

module base64_stream_decoder_top
  import b64d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire dec_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output dec_out_t         out_data
);

  logic      push;
  logic      full;
  logic      pop;
  logic      head_valid;
  b64d_job_t push_job;
  b64d_job_t head;

  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .full     (full),
    .push     (push),
    .job      (push_job)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench for base64_stream_decoder_top: directed and random character streams under random
// stalls on both channels, checked against an in-bench decoder model through a result queue
// depends on b64d_pkg and base64_stream_decoder_top
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_CHARS  = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  dec_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  dec_out_t    out_data;

  base64_stream_decoder_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dec_in_t  chars_to_send[$];
  dec_out_t decoded_results[$];
  int errors = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int rx_hold = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  // decoder model state
  logic [15:0] capacity = MAX_OUTPUT_RESET;
  logic [11:0] pend_bits = '0;
  logic [2:0]  pend_count = '0;
  logic [15:0] bytes_out = '0;
  logic        stopped = 1'b0;
  logic        over_cap = 1'b0;

  function automatic dec_out_t make_result(logic kind, logic [7:0] data, logic [15:0] count,
                                           logic status, logic last);
    dec_out_t r;
    r.kind       = kind;
    r.data_byte  = data;
    r.byte_count = count;
    r.status     = status;
    r.last       = last;
    return r;
  endfunction

  function automatic void decode_char(dec_in_t item);
    char_class_t cls;
    logic [5:0]  sx;
    logic [3:0]  held;
    logic [7:0]  c;
    c   = item.char_in;
    sx  = '0;
    cls = CLS_STOP;
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      cls = CLS_BLANK;
    end else if (c >= "A" && c <= "Z") begin
      cls = CLS_CODE;
      sx  = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      cls = CLS_CODE;
      sx  = 6'(c - "a" + 26);
    end else if (c >= "0" && c <= "9") begin
      cls = CLS_CODE;
      sx  = 6'(c - "0" + 52);
    end else if (c == CH_PLUS) begin
      cls = CLS_CODE;
      sx  = 6'd62;
    end else if (c == CH_SLASH) begin
      cls = CLS_CODE;
      sx  = 6'd63;
    end
    if (!stopped && !over_cap && cls != CLS_BLANK) begin
      if (cls == CLS_STOP) begin
        stopped = 1'b1;
      end else begin
        held      = {1'b0, pend_count} + 4'd6;
        pend_bits = {pend_bits[5:0], sx};
        if (held >= 4'd8) begin
          held = held - 4'd8;
          if (bytes_out >= capacity) begin
            over_cap = 1'b1;
          end else begin
            bytes_out = bytes_out + 16'd1;
            decoded_results.push_back(make_result(KIND_DATA, 8'(pend_bits >> held), bytes_out,
                                                  STATUS_OK, !item.final_char));
          end
        end
        pend_count = held[2:0];
      end
    end
    if (item.final_char) begin
      decoded_results.push_back(make_result(KIND_SUMMARY, 8'd0, bytes_out,
                                            over_cap ? STATUS_OVERFLOW : STATUS_OK, 1'b1));
      pend_bits  = '0;
      pend_count = '0;
      bytes_out  = '0;
      stopped    = 1'b0;
      over_cap   = 1'b0;
    end
  endfunction

  function automatic int draw_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic log_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic string show(dec_out_t r);
    return $sformatf("kind=%0d byte=%02h count=%0d status=%0d last=%0d",
                     r.kind, r.data_byte, r.byte_count, r.status, r.last);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_char(chars_to_send.pop_front());
        tx_gap = draw_gap(tx_calm);
      end
      if (in_valid && !in_ready) begin
        // transaction still pending, hold payload
      end else if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (chars_to_send.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= chars_to_send[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : watch_out
    dec_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_results.size() == 0) begin
          log_error({"unexpected result ", show(out_data)});
        end else begin
          want = decoded_results.pop_front();
          if (out_data.kind !== want.kind || out_data.data_byte !== want.data_byte ||
              out_data.byte_count !== want.byte_count || out_data.status !== want.status ||
              out_data.last !== want.last)
            log_error({"mismatch: expected ", show(want), " got ", show(out_data)});
        end
        rx_gap = draw_gap(rx_calm);
      end
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold   <= rx_hold - 1;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic dec_in_t mk(input logic [7:0] c, input logic fin);
    dec_in_t d;
    d.char_in    = c;
    d.final_char = fin;
    return d;
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++)
      chars_to_send.push_back(mk(s[i], i == s.len() - 1));
  endtask

  function automatic logic [7:0] alpha_char(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? CH_PLUS : CH_SLASH;
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? CH_SPACE : 8'(r);
  endfunction

  function automatic logic [7:0] stop_char();
    case ($urandom_range(0, 2))
      0: return CH_PAD;
      1: return 8'($urandom_range(128, 255));
      default: return CH_DASH;
    endcase
  endfunction

  // one message: mostly well-formed text, some with a stray stop char, some pure noise
  task automatic add_message(output int n);
    dec_in_t msg[$];
    int sel, len, pad;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      len = $urandom_range(1, 8);
      repeat (len) msg.push_back(mk(8'($urandom_range(0, 255)), 1'b0));
    end else begin
      len = $urandom_range(0, 14);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) msg.push_back(mk(blank_char(), 1'b0));
        msg.push_back(mk(alpha_char($urandom_range(0, 63)), 1'b0));
      end
      pad = (len % 4 == 2) ? $urandom_range(0, 2) : (len % 4 == 3) ? $urandom_range(0, 1) : 0;
      repeat (pad) msg.push_back(mk(CH_PAD, 1'b0));
      if (sel < 30 && msg.size() > 0)
        msg.insert($urandom_range(0, msg.size() - 1), mk(stop_char(), 1'b0));
    end
    if (msg.size() == 0) msg.push_back(mk(blank_char(), 1'b0));
    msg[msg.size() - 1].final_char = 1'b1;
    n = msg.size();
    foreach (msg[i]) chars_to_send.push_back(msg[i]);
  endtask

  task automatic wait_results();
    while (chars_to_send.size() != 0 || in_valid || decoded_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    capacity = v;
  endtask

  task automatic fill_chars(input int target);
    int total, n;
    total = 0;
    while (total < target) begin
      add_message(n);
      total += n;
    end
  endtask

  initial begin
    logic [15:0] cap;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset capacity, whitespace, both stop kinds, leftover bits, empty message
    push_str("TW\tFu");
    push_str("+/09 ");
    push_str("az=Q");
    chars_to_send.push_back(mk("A", 1'b0));
    chars_to_send.push_back(mk("Z", 1'b0));
    chars_to_send.push_back(mk(8'hFF, 1'b0));
    chars_to_send.push_back(mk("9", 1'b1));
    chars_to_send.push_back(mk(CH_VT, 1'b1));
    push_str("Zm8");
    wait_idle();
    // zero capacity, then capacity reached mid-message
    write_capacity(16'd0);
    push_str("QUJD");
    wait_idle();
    write_capacity(16'd2);
    push_str("QUJD");
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: cap = 16'hFFFF;
        1: cap = 16'd1;
        2: cap = 16'd0;
        3: cap = 16'($urandom_range(3, 20));
        4: cap = 16'h8000;
        5: cap = 16'($urandom_range(0, 65535));
        6: cap = 16'd2;
        7: cap = 16'($urandom_range(4, 12));
        8: cap = 16'h7FFF;
        default: cap = 16'hFFFF;
      endcase
      write_capacity(cap);
      tx_calm = (p == 3 || p == 5);
      rx_calm = (p == 3);
      if (p == 5) begin
        // long receiver hold while the sender keeps offering characters
        @(posedge clk);
        rx_hold <= 150;
      end
      if (p == 7) begin
        // sender pauses mid-stream until all results are in
        fill_chars(PHASE_CHARS / 2);
        wait_results();
        fill_chars(PHASE_CHARS / 2);
      end else begin
        fill_chars(PHASE_CHARS);
      end
      wait_idle();
    end

    if (decoded_results.size() != 0)
      log_error($sformatf("%0d results never arrived", decoded_results.size()));
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_500_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: base64_stream_decoder_top.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_queue.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder_top.sv
tb/testbench.sv
